### sv/pooled_linked_list_manager_top_macros.svh
// assertion macros for the pooled linked list manager
`ifndef POOLED_LINKED_LIST_MANAGER_TOP_MACROS_SVH
`define POOLED_LINKED_LIST_MANAGER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLM_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, checked outside reset
`define PLM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

`endif

### sv/plm_pkg.sv
// shared types and codes for the pooled linked list manager
`timescale 1ns / 1ps

package plm_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int ST_W      = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_ELEMENT   = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic             valid;
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] value;
        logic             last;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic val_we;
        logic link_we;
    } pool_ctl_t;

endpackage

### sv/plm_pool.sv
// node pool memories: values and links, registered read, link reset via valid bits
`timescale 1ns / 1ps

module plm_pool #(
    parameter int DEPTH = plm_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  plm_pkg::pool_ctl_t            ctl,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      val_waddr,
    input  logic [plm_pkg::VAL_W-1:0]     val_wdata,
    input  logic [$clog2(DEPTH)-1:0]      link_waddr,
    input  logic [$clog2(DEPTH+1)-1:0]    link_wdata,
    output logic [plm_pkg::VAL_W-1:0]     val_q,
    output logic [$clog2(DEPTH+1)-1:0]    link_q
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    logic [plm_pkg::VAL_W-1:0] val_mem [DEPTH];
    logic [LW-1:0]             link_mem [DEPTH];
    logic [DEPTH-1:0]          link_vld_reg;

    logic [plm_pkg::VAL_W-1:0] val_q_reg;
    logic [LW-1:0]             link_mem_q_reg;
    logic [IW-1:0]             rd_idx_reg;
    logic                      rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (ctl.val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctl.link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctl.rd_en) begin
            val_q_reg      <= val_mem[rd_addr];
            link_mem_q_reg <= link_mem[rd_addr];
            rd_idx_reg     <= rd_addr;
            rd_vld_reg     <= link_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (ctl.link_we) begin
            link_vld_reg[link_waddr] <= 1'b1;
        end
    end

    // unwritten link reads as its reset value, the next entry (null past the end)
    assign val_q  = val_q_reg;
    assign link_q = rd_vld_reg ? link_mem_q_reg : LW'(rd_idx_reg) + LW'(1);

endmodule

### sv/plm_ctrl.sv
// sequencer: walks one node per cycle for insert, remove, unstalled listing
`timescale 1ns / 1ps

module plm_ctrl #(
    parameter int DEPTH = plm_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [plm_pkg::OP_W-1:0]      in_op,
    input  logic [plm_pkg::VAL_W-1:0]     in_value,
    input  logic                          out_free,
    output plm_pkg::res_t                 res,
    output plm_pkg::pool_ctl_t            ctl,
    output logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [$clog2(DEPTH)-1:0]      val_waddr,
    output logic [plm_pkg::VAL_W-1:0]     val_wdata,
    output logic [$clog2(DEPTH)-1:0]      link_waddr,
    output logic [$clog2(DEPTH+1)-1:0]    link_wdata,
    input  logic [plm_pkg::VAL_W-1:0]     val_q,
    input  logic [$clog2(DEPTH+1)-1:0]    link_q
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);
    localparam logic [LW-1:0] LINK_NULL = LW'(DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INS   = 4'd1;
    localparam logic [3:0] S_INS_B = 4'd2;
    localparam logic [3:0] S_INS_W = 4'd3;
    localparam logic [3:0] S_REM   = 4'd4;
    localparam logic [3:0] S_REM_W = 4'd5;
    localparam logic [3:0] S_REM_U = 4'd6;
    localparam logic [3:0] S_REM_F = 4'd7;
    localparam logic [3:0] S_LST   = 4'd8;
    localparam logic [3:0] S_LST_W = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0]                state_reg, state_next;
    logic [LW-1:0]             list_head_reg, list_head_next;
    logic [LW-1:0]             free_head_reg, free_head_next;
    logic [plm_pkg::VAL_W-1:0] val_reg, val_next;
    logic [IW-1:0]             node_reg, node_next;
    logic [IW-1:0]             t_reg, t_next;
    logic [LW-1:0]             prev_reg, prev_next;
    logic [plm_pkg::ST_W-1:0]  st_reg, st_next;

    logic link_is_null;
    logic list_empty;
    logic pool_full;
    logic match;

    assign link_is_null = (link_q >= LINK_NULL);
    assign list_empty   = (list_head_reg >= LINK_NULL);
    assign pool_full    = (free_head_reg >= LINK_NULL);
    assign match        = (val_q == val_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign val_waddr = free_head_reg[IW-1:0];
    assign val_wdata = val_reg;

    always_comb begin
        state_next     = state_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        val_next       = val_reg;
        node_next      = node_reg;
        t_next         = t_reg;
        prev_next      = prev_reg;
        st_next        = st_reg;
        ctl            = '0;
        rd_addr        = t_reg;
        link_waddr     = t_reg;
        link_wdata     = LINK_NULL;
        res            = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    val_next = in_value;
                    unique case (in_op)
                        plm_pkg::OP_INSERT: state_next = S_INS;
                        plm_pkg::OP_REMOVE: state_next = S_REM;
                        plm_pkg::OP_LIST:   state_next = S_LST;
                        plm_pkg::OP_NONE:   state_next = S_IDLE;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (pool_full) begin
                    st_next    = plm_pkg::ST_FULL;
                    state_next = S_EMIT;
                end else begin
                    ctl.rd_en  = 1'b1;
                    ctl.val_we = 1'b1;
                    rd_addr    = free_head_reg[IW-1:0];
                    node_next  = free_head_reg[IW-1:0];
                    state_next = S_INS_B;
                end
            end
            S_INS_B: begin
                free_head_next = link_q;
                ctl.link_we    = 1'b1;
                link_waddr     = node_reg;
                link_wdata     = LINK_NULL;
                if (list_empty) begin
                    list_head_next = LW'(node_reg);
                    st_next        = plm_pkg::ST_INSERTED;
                    state_next     = S_EMIT;
                end else begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = list_head_reg[IW-1:0];
                    t_next     = list_head_reg[IW-1:0];
                    state_next = S_INS_W;
                end
            end
            S_INS_W: begin
                if (link_is_null) begin
                    ctl.link_we = 1'b1;
                    link_waddr  = t_reg;
                    link_wdata  = LW'(node_reg);
                    st_next     = plm_pkg::ST_INSERTED;
                    state_next  = S_EMIT;
                end else begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = link_q[IW-1:0];
                    t_next    = link_q[IW-1:0];
                end
            end
            S_REM: begin
                if (list_empty) begin
                    st_next    = plm_pkg::ST_NOT_FOUND;
                    state_next = S_EMIT;
                end else begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = list_head_reg[IW-1:0];
                    t_next     = list_head_reg[IW-1:0];
                    prev_next  = LINK_NULL;
                    state_next = S_REM_W;
                end
            end
            S_REM_W: begin
                priority if (match) begin
                    state_next = S_REM_U;
                end else if (link_is_null) begin
                    st_next    = plm_pkg::ST_NOT_FOUND;
                    state_next = S_EMIT;
                end else begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = link_q[IW-1:0];
                    prev_next = LW'(t_reg);
                    t_next    = link_q[IW-1:0];
                end
            end
            S_REM_U: begin
                if (prev_reg >= LINK_NULL) begin
                    list_head_next = link_q;
                end else begin
                    ctl.link_we = 1'b1;
                    link_waddr  = prev_reg[IW-1:0];
                    link_wdata  = link_q;
                end
                state_next = S_REM_F;
            end
            S_REM_F: begin
                ctl.link_we    = 1'b1;
                link_waddr     = t_reg;
                link_wdata     = free_head_reg;
                free_head_next = LW'(t_reg);
                st_next        = plm_pkg::ST_REMOVED;
                state_next     = S_EMIT;
            end
            S_LST: begin
                if (list_empty) begin
                    st_next    = plm_pkg::ST_EMPTY;
                    state_next = S_EMIT;
                end else begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = list_head_reg[IW-1:0];
                    state_next = S_LST_W;
                end
            end
            S_LST_W: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    res.status = plm_pkg::ST_ELEMENT;
                    res.value  = val_q;
                    res.last   = link_is_null;
                    if (link_is_null) begin
                        state_next = S_IDLE;
                    end else begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = link_q[IW-1:0];
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    res.valid  = 1'b1;
                    res.status = st_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            list_head_reg <= LINK_NULL;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        node_reg <= node_next;
        t_reg    <= t_next;
        prev_reg <= prev_next;
        st_reg   <= st_next;
    end

endmodule

### sv/pooled_linked_list_manager_top.sv
// top level of the pooled linked list manager: sequencer, node pool, result register
//
//  channel | direction | fields
//  s_      | in        | tdata: operation, item_value
//  m_      | out       | tdata: status, out_value; tlast: last
//
// insert walks the list to its tail, remove compares node by node until the value is found
// or the list ends, and listing reads each node in turn; an operation takes longer while
// results stall
// the walk is bound by the node pool's single registered read port
// reset puts all nodes on the free list at once, no clearing pass
// a stalled result register holds the sequencer; the next item is taken while the last
// result of the previous one still waits
`timescale 1ns / 1ps

`include "pooled_linked_list_manager_top_macros.svh"

module pooled_linked_list_manager_top #(
    parameter int DEPTH = plm_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], item_value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // status[2:0], out_value[34:3], zero pad
    output logic        m_tlast
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH+1);

    plm_pkg::res_t             res;
    plm_pkg::pool_ctl_t        ctl;
    logic [IW-1:0]             rd_addr;
    logic [IW-1:0]             val_waddr;
    logic [plm_pkg::VAL_W-1:0] val_wdata;
    logic [IW-1:0]             link_waddr;
    logic [LW-1:0]             link_wdata;
    logic [plm_pkg::VAL_W-1:0] val_q;
    logic [LW-1:0]             link_q;
    logic                      out_free;

    logic                      m_tvalid_reg;
    logic [plm_pkg::ST_W-1:0]  m_status_reg;
    logic [plm_pkg::VAL_W-1:0] m_value_reg;
    logic                      m_tlast_reg;

    logic                      m_single;
    logic                      s_busy_op;

    assign out_free = !m_tvalid_reg || m_tready;

    plm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tdata[1:0]),
        .in_value   (s_tdata[33:2]),
        .out_free   (out_free),
        .res        (res),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_q      (val_q),
        .link_q     (link_q)
    );

    plm_pool #(.DEPTH(DEPTH)) u_pool (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .rd_addr    (rd_addr),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .val_q      (val_q),
        .link_q     (link_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            m_status_reg <= res.status;
            m_value_reg  <= res.value;
            m_tlast_reg  <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, m_value_reg, m_status_reg};
    assign m_tlast  = m_tlast_reg;

    assign m_single  = m_tvalid && (m_tdata[2:0] != plm_pkg::ST_ELEMENT);
    assign s_busy_op = s_tvalid && s_tready && (s_tdata[1:0] != plm_pkg::OP_NONE);

    `PLM_ASSERT_SAME(a_single_is_last, aclk, aresetn, m_single, m_tlast)
    `PLM_ASSERT_SAME(a_single_zero_value, aclk, aresetn, m_single, m_tdata[34:3] == '0)
    `PLM_ASSERT_NEXT(a_one_item_at_once, aclk, aresetn, s_busy_op, !s_tready)

endmodule
